// ----- sv/owned_timer_event_table_macros.svh -----
// ----------------------------------------------------------------------------
// owned_timer_event_table_macros.svh
// Assertion macros shared by the timer event table RTL.
// ----------------------------------------------------------------------------
`ifndef OWNED_TIMER_EVENT_TABLE_MACROS_SVH
`define OWNED_TIMER_EVENT_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define OTE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define OTE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/ote_pkg.sv -----
// ----------------------------------------------------------------------------
// ote_pkg
// Shared types, codes and field widths of the timer event table.
// ----------------------------------------------------------------------------
package ote_pkg;

    // Field widths of the channel payloads
    localparam int OPCODE_W  = 2;
    localparam int DELAY_W   = 16;
    localparam int TASK_W    = 8;
    localparam int OWNER_W   = 6;
    localparam int ARG_W     = 16;
    localparam int KIND_W    = 3;
    localparam int STATUS_W  = 2;
    localparam int SLOT_W    = 4;
    localparam int REMOVED_W = 5;
    localparam int MAP_W     = 2 ** OWNER_W;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ADD    = 2'd0,
        OP_TICK   = 2'd1,
        OP_CANCEL = 2'd2,
        OP_STATUS = 2'd3
    } t_opcode;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD     = 3'd0,
        KIND_FIRED   = 3'd1,
        KIND_ABORTED = 3'd2,
        KIND_CANCEL  = 3'd3,
        KIND_STATUS  = 3'd4,
        KIND_TICK    = 3'd5
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ADD_OK     = 2'd0,
        ADD_ABSENT = 2'd1,
        ADD_FULL   = 2'd2
    } t_add_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;   // latch the accepted beat
        logic step;   // act on the current slot and move on
        logic fin;    // load the closing result
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic skip_scan;  // beat at the input needs no slot walk
        logic emit;       // current slot gives a result
        logic stop;       // add found its free slot
        logic last_slot;  // current slot is the final one
        logic out_free;   // output register can take a result
    } t_dp_status;

endpackage

// ----- sv/ote_if.sv -----
// ----------------------------------------------------------------------------
// ote_if
// Valid/ready channels of the timer event table: request and result beats.
// ----------------------------------------------------------------------------
interface ote_in_if;
    import ote_pkg::*;

    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic                is_repeating;
    logic [DELAY_W-1:0]  delay_ms;
    logic [TASK_W-1:0]   task_id;
    logic                has_owner;
    logic [OWNER_W-1:0]  owner_id;
    logic [ARG_W-1:0]    argument_tag;
    logic                owner_present;

    modport source (
        output valid, opcode, is_repeating, delay_ms, task_id, has_owner,
               owner_id, argument_tag, owner_present,
        input  ready
    );
    modport sink (
        input  valid, opcode, is_repeating, delay_ms, task_id, has_owner,
               owner_id, argument_tag, owner_present,
        output ready
    );
endinterface

interface ote_out_if;
    import ote_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    kind;
    logic [STATUS_W-1:0]  status;
    logic [SLOT_W-1:0]    slot;
    logic [TASK_W-1:0]    task_id_res;
    logic                 has_owner_res;
    logic [OWNER_W-1:0]   owner_id_res;
    logic [ARG_W-1:0]     argument_tag_res;
    logic [REMOVED_W-1:0] removed_count;
    logic                 last;

    modport source (
        output valid, kind, status, slot, task_id_res, has_owner_res,
               owner_id_res, argument_tag_res, removed_count, last,
        input  ready
    );
    modport sink (
        input  valid, kind, status, slot, task_id_res, has_owner_res,
               owner_id_res, argument_tag_res, removed_count, last,
        output ready
    );
endinterface

// ----- sv/ote_ctrl.sv -----
// ----------------------------------------------------------------------------
// ote_ctrl
// Sequencer of the timer event table: accept, walk the slots, close out.
// ----------------------------------------------------------------------------
module ote_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ote_pkg::t_dp_status i_status,
    output ote_pkg::t_dp_cmd    o_cmd
);
    import ote_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_step;

    // Walk one slot per cycle; a slot with a result waits for the output register
    assign w_step = (r_state == ST_SCAN) && (!i_status.emit || i_status.out_free);

    // Hold the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_status.skip_scan ? ST_FIN : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_step && (i_status.stop || i_status.last_slot)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Commands and handshake
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_SCAN: begin
                o_cmd.step = w_step;
            end
            ST_FIN: begin
                o_cmd.fin = i_status.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- sv/ote_dp.sv -----
// ----------------------------------------------------------------------------
// ote_dp
// Datapath of the timer event table: slot memory, valid bits, owner map,
// slot walk index and output register.
// ----------------------------------------------------------------------------
module ote_dp #(
    parameter int SLOTS      = 16,
    parameter int OWNERS     = 64,
    parameter int DELAY_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ote_pkg::t_dp_cmd                  i_cmd,
    output ote_pkg::t_dp_status               o_status,
    // request payload
    input  logic [ote_pkg::OPCODE_W-1:0]      i_opcode,
    input  logic                              i_is_repeating,
    input  logic [ote_pkg::DELAY_W-1:0]       i_delay_ms,
    input  logic [ote_pkg::TASK_W-1:0]        i_task_id,
    input  logic                              i_has_owner,
    input  logic [ote_pkg::OWNER_W-1:0]       i_owner_id,
    input  logic [ote_pkg::ARG_W-1:0]         i_argument_tag,
    input  logic                              i_owner_present,
    // result side
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [ote_pkg::KIND_W-1:0]        o_kind,
    output logic [ote_pkg::STATUS_W-1:0]      o_status_code,
    output logic [ote_pkg::SLOT_W-1:0]        o_slot,
    output logic [ote_pkg::TASK_W-1:0]        o_task_id_res,
    output logic                              o_has_owner_res,
    output logic [ote_pkg::OWNER_W-1:0]       o_owner_id_res,
    output logic [ote_pkg::ARG_W-1:0]         o_argument_tag_res,
    output logic [ote_pkg::REMOVED_W-1:0]     o_removed_count,
    output logic                              o_last
);
    import ote_pkg::*;

    localparam int IW = $clog2(SLOTS);

    typedef struct packed {
        logic                  repeating;
        logic [DELAY_BITS-1:0] remaining;
        logic [DELAY_BITS-1:0] period;
        logic [TASK_W-1:0]     task_id;
        logic                  owned;
        logic [OWNER_W-1:0]    owner;
        logic [ARG_W-1:0]      arg;
    } t_entry;

    // Slot memory and its registered read port
    t_entry mem [SLOTS];
    t_entry r_rd;

    logic [IW-1:0]     r_idx;
    logic [IW-1:0]     n_idx;
    logic [SLOTS-1:0]  r_valid;
    logic [OWNERS-1:0] r_map;
    t_opcode           r_op;
    logic [OWNER_W-1:0] r_owner;
    t_entry            r_new;
    t_add_status       r_add_status;
    logic [IW-1:0]     r_add_slot;
    logic [REMOVED_W-1:0] r_removed;

    // Output register
    logic                 r_out_valid;
    t_kind                r_kind;
    t_add_status          r_status_code;
    logic [SLOT_W-1:0]    r_slot;
    logic [TASK_W-1:0]    r_task;
    logic                 r_owned;
    logic [OWNER_W-1:0]   r_owner_res;
    logic [ARG_W-1:0]     r_arg;
    logic [REMOVED_W-1:0] r_removed_res;
    logic                 r_last;

    logic [MAP_W-1:0]      w_map_ext;
    logic                  w_in_absent;
    logic                  w_cur_valid;
    logic [DELAY_BITS-1:0] w_rem_dec;
    logic                  w_due;
    logic                  w_alive;
    logic                  w_last_slot;
    logic                  w_is_add;
    logic                  w_is_tick;
    logic                  w_is_cancel;
    logic                  w_cancel_hit;
    logic                  w_rearm;
    logic                  w_we;
    t_entry                w_wdata;
    logic                  w_out_load;

    // Owners beyond the map read as absent
    assign w_map_ext   = MAP_W'(r_map);
    assign w_in_absent = i_has_owner && !w_map_ext[i_owner_id];

    // Decode the current slot
    assign w_is_add     = (r_op == OP_ADD);
    assign w_is_tick    = (r_op == OP_TICK);
    assign w_is_cancel  = (r_op == OP_CANCEL);
    assign w_cur_valid  = r_valid[r_idx];
    assign w_rem_dec    = (r_rd.remaining != '0) ? r_rd.remaining - 1'b1 : '0;
    assign w_due        = w_cur_valid && (w_rem_dec == '0);
    assign w_alive      = !r_rd.owned || w_map_ext[r_rd.owner];
    assign w_rearm      = w_alive && r_rd.repeating;
    assign w_last_slot  = (r_idx == IW'(SLOTS - 1));
    assign w_cancel_hit = w_cur_valid && r_rd.owned && (r_rd.owner == r_owner);

    // Status towards the controller
    always_comb begin
        o_status.skip_scan = (t_opcode'(i_opcode) == OP_STATUS) ||
                             ((t_opcode'(i_opcode) == OP_ADD) && w_in_absent);
        o_status.emit      = w_is_tick && w_due;
        o_status.stop      = w_is_add && !w_cur_valid;
        o_status.last_slot = w_last_slot;
        o_status.out_free  = !r_out_valid || i_out_ready;
    end

    // Advance the walk index; it rests at zero between beats
    always_comb begin
        n_idx = r_idx;
        if (i_cmd.step) begin
            n_idx = (o_status.stop || w_last_slot) ? '0 : r_idx + 1'b1;
        end
    end

    // Write back: a new entry on add, the counted-down entry on tick
    always_comb begin
        w_we    = i_cmd.step && ((w_is_tick && w_cur_valid) || (w_is_add && !w_cur_valid));
        w_wdata = r_rd;
        if (w_is_add) begin
            w_wdata = r_new;
        end else begin
            w_wdata.remaining = w_due ? r_rd.period : w_rem_dec;
        end
    end

    // Slot memory: one write, one registered read at the next index
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[r_idx] <= w_wdata;
        end
        r_rd <= mem[n_idx];
    end

    // Walk index, valid bits and owner map
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= '0;
            r_map   <= '0;
        end else begin
            r_idx <= n_idx;
            if (i_cmd.step) begin
                if (w_is_tick && w_due && !w_rearm) begin
                    r_valid[r_idx] <= 1'b0;
                end else if (w_is_cancel && w_cancel_hit) begin
                    r_valid[r_idx] <= 1'b0;
                end else if (w_is_add && !w_cur_valid) begin
                    r_valid[r_idx] <= 1'b1;
                end
            end
            if (i_cmd.load && (t_opcode'(i_opcode) == OP_STATUS)) begin
                for (int i = 0; i < OWNERS; i++) begin
                    if (i_owner_id == OWNER_W'(i)) begin
                        r_map[i] <= i_owner_present;
                    end
                end
            end
        end
    end

    // Latch the beat and keep the per-beat tallies
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op               <= t_opcode'(i_opcode);
            r_owner            <= i_owner_id;
            r_new.repeating    <= i_is_repeating;
            r_new.remaining    <= DELAY_BITS'(i_delay_ms);
            r_new.period       <= DELAY_BITS'(i_delay_ms);
            r_new.task_id      <= i_task_id;
            r_new.owned        <= i_has_owner;
            r_new.owner        <= i_has_owner ? i_owner_id : '0;
            r_new.arg          <= i_argument_tag;
            r_add_status       <= w_in_absent ? ADD_ABSENT : ADD_FULL;
            r_add_slot         <= '0;
            r_removed          <= '0;
        end else if (i_cmd.step) begin
            if (w_is_add && !w_cur_valid) begin
                r_add_status <= ADD_OK;
                r_add_slot   <= r_idx;
            end
            if (w_is_cancel && w_cancel_hit) begin
                r_removed <= r_removed + 1'b1;
            end
        end
    end

    assign w_out_load = (i_cmd.step && o_status.emit) || i_cmd.fin;

    // Output valid: set on load, drop once the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload: a due event, or the closing result of the beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.step && o_status.emit) begin
            r_kind        <= w_alive ? KIND_FIRED : KIND_ABORTED;
            r_status_code <= ADD_OK;
            r_slot        <= SLOT_W'(r_idx);
            r_task        <= r_rd.task_id;
            r_owned       <= r_rd.owned;
            r_owner_res   <= r_rd.owner;
            r_arg         <= r_rd.arg;
            r_removed_res <= '0;
            r_last        <= 1'b0;
        end else if (i_cmd.fin) begin
            r_status_code <= ADD_OK;
            r_slot        <= '0;
            r_task        <= '0;
            r_owned       <= 1'b0;
            r_owner_res   <= '0;
            r_arg         <= '0;
            r_removed_res <= '0;
            r_last        <= 1'b1;
            case (r_op)
                OP_ADD: begin
                    r_kind        <= KIND_ADD;
                    r_status_code <= r_add_status;
                    r_slot        <= SLOT_W'(r_add_slot);
                end
                OP_TICK: begin
                    r_kind <= KIND_TICK;
                end
                OP_CANCEL: begin
                    r_kind        <= KIND_CANCEL;
                    r_removed_res <= r_removed;
                end
                default: begin
                    r_kind <= KIND_STATUS;
                end
            endcase
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_kind             = r_kind;
    assign o_status_code      = r_status_code;
    assign o_slot             = r_slot;
    assign o_task_id_res      = r_task;
    assign o_has_owner_res    = r_owned;
    assign o_owner_id_res     = r_owner_res;
    assign o_argument_tag_res = r_arg;
    assign o_removed_count    = r_removed_res;
    assign o_last             = r_last;

endmodule

// ----- sv/owned_timer_event_table.sv -----
// ----------------------------------------------------------------------------
// owned_timer_event_table
// Table of pending one-shot and repeating timed events with owner tracking.
//
//   channel  dir  handshake          beat carries
//   i_in     in   valid/ready        opcode and request fields
//   o_out    out  valid/ready        one result (several per tick)
//
// One request at a time. Add, tick and cancel walk the slot memory one slot
// per cycle unless the walk is held, an add stopping early at free slot k;
// a status op or a refused add skips the walk and goes straight to close.
// Each due event on a tick holds the walk until the output register is free,
// and the closing result of every request waits for it likewise.
// Synchronous reset clears valid bits and the owner map; no clearing pass.
// ----------------------------------------------------------------------------
`include "owned_timer_event_table_macros.svh"

module owned_timer_event_table #(
    parameter int SLOTS      = 16,
    parameter int OWNERS     = 64,
    parameter int DELAY_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ote_in_if.sink      i_in,
    ote_out_if.source   o_out
);
    import ote_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // Sequencer
    ote_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Slot store and result register
    ote_dp #(
        .SLOTS      (SLOTS),
        .OWNERS     (OWNERS),
        .DELAY_BITS (DELAY_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_status           (w_status),
        .i_opcode           (i_in.opcode),
        .i_is_repeating     (i_in.is_repeating),
        .i_delay_ms         (i_in.delay_ms),
        .i_task_id          (i_in.task_id),
        .i_has_owner        (i_in.has_owner),
        .i_owner_id         (i_in.owner_id),
        .i_argument_tag     (i_in.argument_tag),
        .i_owner_present    (i_in.owner_present),
        .i_out_ready        (o_out.ready),
        .o_out_valid        (o_out.valid),
        .o_kind             (o_out.kind),
        .o_status_code      (o_out.status),
        .o_slot             (o_out.slot),
        .o_task_id_res      (o_out.task_id_res),
        .o_has_owner_res    (o_out.has_owner_res),
        .o_owner_id_res     (o_out.owner_id_res),
        .o_argument_tag_res (o_out.argument_tag_res),
        .o_removed_count    (o_out.removed_count),
        .o_last             (o_out.last)
    );

    // Checks
    `OTE_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready, "request accepted while another is in flight")
    `OTE_ASSERT_NEXT(a_ready_after_close, i_clk, i_rst_n, w_cmd.fin, i_in.ready, "not ready after the closing result")
    `OTE_ASSERT_NOW(a_last_matches_kind, i_clk, i_rst_n, o_out.valid, o_out.last == ((o_out.kind != KIND_FIRED) && (o_out.kind != KIND_ABORTED)), "last flag disagrees with result kind")

endmodule
